// File: rtl/sna_pkg.sv
// package for the script number bitwise alu
// request and result structs, command codes, conversion helpers; no dependencies
package sna_pkg;

    typedef enum logic [2:0] {
        CMD_AND = 3'd0,
        CMD_OR  = 3'd1,
        CMD_XOR = 3'd2,
        CMD_SHL = 3'd3,
        CMD_SAR = 3'd4,
        CMD_SHR = 3'd5,
        CMD_NOT = 3'd6
    } cmd_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [63:0] operand_a;
        logic [63:0] operand_b;
    } req_t;

    typedef struct packed {
        logic [63:0]        result_double;
        logic signed [32:0] result_integer;
    } rsp_t;

    localparam logic [10:0] EXP_BIAS_INT = 11'd1075;
    localparam logic [10:0] EXP_ONE      = 11'd1023;

    // binary64 to 32-bit word, truncation then modulo 2^32
    function automatic logic [31:0] to_word(input logic [63:0] bits);
        logic [10:0] expo;
        logic [52:0] mant;
        logic [31:0] mag;
        logic [10:0] sh;
        begin
            expo = bits[62:52];
            mant = {1'b1, bits[51:0]};
            mag  = '0;
            if (expo == 11'h7ff || expo == 11'd0) begin
                mag = '0;
            end else if (expo >= EXP_BIAS_INT + 11'd32) begin
                mag = '0;
            end else if (expo >= EXP_BIAS_INT) begin
                sh  = expo - EXP_BIAS_INT;
                mag = 32'(mant << sh[4:0]);
            end else if (expo >= EXP_ONE) begin
                sh  = EXP_BIAS_INT - expo;
                mag = 32'(mant >> sh[5:0]);
            end else begin
                mag = '0;
            end
            if (bits[63])
                mag = 32'(0) - mag;
            to_word = mag;
        end
    endfunction

endpackage

// File: rtl/sna_convert.sv
// integer to binary64 conversion, exact for 33-bit signed values
// uses sna_pkg
module sna_convert (
    input  logic signed [32:0] value,
    output logic [63:0]        dbl
);
    import sna_pkg::*;

    logic [32:0] mag;
    logic [5:0]  msb;
    logic [32:0] norm;
    logic [10:0] expo;

    always_comb
    begin
        mag = value[32] ? 33'(-value) : value;
        msb = '0;
        for (int i = 0; i < 33; i++)
        begin
            if (mag[i])
                msb = 6'(i);
        end
        norm = mag << (6'd32 - msb);
        expo = 11'd1023 + 11'(msb);
        if (mag == '0)
            dbl = '0;
        else
            dbl = {value[32], expo, norm[31:0], 20'd0};
    end
endmodule

// File: rtl/script_number_bitwise_alu.sv
// top level of the script number bitwise alu
// uses sna_pkg and sna_convert
//
//  channel | valid     | ready     | payload
//  input   | in_valid  | in_ready  | in_data  (req_t)
//  output  | out_valid | out_ready | out_data (rsp_t)
//
// one request per cycle while in_ready is high; a result appears the cycle after acceptance
// each result is held in the single result register
// in_ready is high whenever the result register is empty or being taken
// reset clears out_valid only
module script_number_bitwise_alu (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  sna_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output sna_pkg::rsp_t out_data
);
    import sna_pkg::*;

    logic [31:0]        a, b, w;
    logic [4:0]         s;
    logic               uns, bad;
    logic signed [32:0] v;
    logic [63:0]        dbl;
    logic               valid_reg;
    rsp_t               data_reg, data_next;

    always_comb
    begin
        a   = to_word(in_data.operand_a);
        b   = to_word(in_data.operand_b);
        s   = b[4:0];
        uns = 1'b0;
        bad = 1'b0;
        case (in_data.command)
            CMD_AND: w = a & b;
            CMD_OR:  w = a | b;
            CMD_XOR: w = a ^ b;
            CMD_SHL: w = a << s;
            CMD_SAR: w = 32'($signed(a) >>> s);
            CMD_SHR: begin w = a >> s; uns = 1'b1; end
            CMD_NOT: w = ~a;
            default: begin w = '0; bad = 1'b1; end
        endcase
        v = uns ? $signed({1'b0, w}) : $signed({w[31], w});
    end

    sna_convert u_convert (.value(v), .dbl(dbl));

    always_comb
    begin
        data_next.result_double  = bad ? 64'd0 : dbl;
        data_next.result_integer = bad ? 33'sd0 : v;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end
endmodule

// File: dv/tb_script_number_bitwise_alu.sv
// testbench for the script number bitwise alu: random and directed requests
// checked against a behavioral predictor; depends on sna_pkg and the rtl top
module tb_script_number_bitwise_alu;
    timeunit 1ns;
    timeprecision 1ps;
    import sna_pkg::*;

    // converts a binary64 pattern to a 32-bit word, truncation then modulo 2^32
    function automatic logic [31:0] number_to_word(input logic [63:0] bits);
        int          ex;
        logic [63:0] frac;
        logic [31:0] mag;
        begin
            ex   = int'(bits[62:52]) - 1075;
            frac = {11'd0, 1'b1, bits[51:0]};
            mag  = '0;
            if (bits[62:52] == 11'h7ff || bits[62:52] == 11'd0)
                mag = '0;
            else if (ex >= 32)
                mag = '0;
            else if (ex >= 0)
                mag = 32'(frac << ex);
            else if (ex > -64)
                mag = 32'(frac >> (-ex));
            if (bits[63])
                mag = -mag;
            return mag;
        end
    endfunction

    function automatic rsp_t compute_bitwise(input req_t r);
        logic [31:0]        a;
        logic [31:0]        b;
        logic [31:0]        w;
        logic [4:0]         s;
        logic signed [63:0] v;
        rsp_t               o;
        begin
            a = number_to_word(r.operand_a);
            b = number_to_word(r.operand_b);
            s = b[4:0];
            o = '0;
            w = '0;
            case (r.command)
                CMD_AND: w = a & b;
                CMD_OR:  w = a | b;
                CMD_XOR: w = a ^ b;
                CMD_SHL: w = a << s;
                CMD_SAR: w = $signed(a) >>> s;
                CMD_SHR: w = a >> s;
                CMD_NOT: w = ~a;
                default: return o;
            endcase
            if (r.command == CMD_SHR)
                v = {32'd0, w};
            else
                v = {{32{w[31]}}, w};
            o.result_double  = $realtobits(real'(v));
            o.result_integer = v[32:0];
            return o;
        end
    endfunction

    class result_board;
        rsp_t pending[$];
        int   errors;

        function void note_request(req_t r);
            pending.push_back(compute_bitwise(r));
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (pending.size() == 0) begin
                $display("%t unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.result_double !== want.result_double) begin
                $display("%t result_double expected %h actual %h", $time,
                         want.result_double, got.result_double);
                errors++;
            end
            if (got.result_integer !== want.result_integer) begin
                $display("%t result_integer expected %h actual %h", $time,
                         want.result_integer, got.result_integer);
                errors++;
            end
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_ready;
    req_t  in_data;
    logic  out_valid;
    logic  out_ready;
    rsp_t  out_data;

    result_board board;
    int          send_idle;
    int          recv_idle;
    bit          hold_off;

    script_number_bitwise_alu dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // mostly numbers that land in the interesting conversion ranges
    function automatic logic [63:0] pick_number();
        logic [63:0] x;
        begin
            x = rand64();
            case ($urandom_range(0, 9))
                0, 1: ;
                2, 3, 4: x[62:52] = 11'($urandom_range(1023, 1055));
                5, 6: x[62:52] = 11'($urandom_range(1056, 1110));
                7: x[62:52] = 11'($urandom_range(1000, 1023));
                8: x[62:52] = $urandom_range(0, 1) ? 11'h7ff : 11'h000;
                default: x = $realtobits(real'($signed($urandom_range(0, 80)) - 40));
            endcase
            return x;
        end
    endfunction

    // valid drops only while idling, so back-to-back requests keep it high
    task automatic send_request(input req_t r);
        begin
            while ($urandom_range(0, 99) < send_idle)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= r;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            board.note_request(r);
        end
    endtask

    task automatic send_random(input int count);
        req_t r;
        begin
            repeat (count)
            begin
                r.command   = 3'($urandom_range(0, 7));
                r.operand_a = pick_number();
                r.operand_b = pick_number();
                send_request(r);
            end
        end
    endtask

    // receiver: random stall, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(out_data);
        if (hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    initial
    begin
        logic [63:0] edge_vals[12];
        req_t        r;
        int          k;
        int          wait_cycles;
        board     = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        hold_off  = 1'b0;
        send_idle = 22;
        recv_idle = 74;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        edge_vals = '{64'h7ff8000000000000, 64'h7ff0000000000000, 64'hfff0000000000000,
                      64'h8000000000000000, 64'h000fffffffffffff, 64'hbfe0000000000000,
                      64'h41efffffffe00000, 64'h43e0000000000001, 64'hc1e0000000000000,
                      64'hffefffffffffffff, 64'h403f000000000000, 64'h41f0000000000000};
        // every command over the edge values, plus the unused code
        for (k = 0; k < 24; k++)
        begin
            r.command   = 3'(k % 8);
            r.operand_a = edge_vals[k % 12];
            r.operand_b = edge_vals[(k * 5 + 3) % 12];
            send_request(r);
        end
        send_random(250);

        send_idle = 74;
        recv_idle = 22;
        send_random(200);

        // long hold-off so the block fills and stalls the sender
        send_idle = 0;
        recv_idle = 0;
        fork
            begin
                hold_off = 1'b1;
                for (wait_cycles = 0; wait_cycles < 60; wait_cycles++)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            send_random(20);
        join
        send_random(260);
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (board.pending.size() != 0 && wait_cycles < 10000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (5) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
rtl/sna_pkg.sv
rtl/sna_convert.sv
rtl/script_number_bitwise_alu.sv
dv/tb_script_number_bitwise_alu.sv
